// ===== hw/rtl/entry_pool_free_list_unit_assert.svh =====
// Assertion macros shared by the entry pool RTL.
`ifndef ENTRY_POOL_FREE_LIST_UNIT_ASSERT_SVH
`define ENTRY_POOL_FREE_LIST_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define EPFL_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("epfl: implication check failed");
`define EPFL_ASSERT_ALWAYS(label, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("epfl: invariant check failed");
`else
`define EPFL_ASSERT_IMPL(label, ante, cons)
`define EPFL_ASSERT_ALWAYS(label, expr)
`endif
`endif

// ===== hw/rtl/epfl_pkg.sv =====
// Shared types and codes of the entry pool free list unit.
package epfl_pkg;

	localparam int CMD_W    = 2;
	localparam int NUM_W    = 6;
	localparam int DATA_W   = 32;
	localparam int STATUS_W = 2;

	localparam logic [CMD_W-1:0] CMD_ALLOC   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_LIST    = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EXHAUSTED  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_RANGE      = 2'd2;
	localparam logic [STATUS_W-1:0] ST_NOT_ACTIVE = 2'd3;

	typedef logic [1:0] emit_sel_t;
	localparam emit_sel_t EMIT_STATUS = 2'd0;
	localparam emit_sel_t EMIT_ALLOC  = 2'd1;
	localparam emit_sel_t EMIT_LIST   = 2'd2;

	typedef struct packed {
		logic                load;
		logic                rd_free;
		logic                rd_cur;
		logic                walk_step;
		logic                walk_adv;
		logic                alloc_commit;
		logic                unlink;
		logic                free_push;
		logic                emit;
		emit_sel_t           emit_sel;
		logic [STATUS_W-1:0] status;
	} ctl_t;

	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic             range_ok;
		logic             free_ok;
		logic             cur_ok;
		logic             cur_hit;
		logic             out_free;
	} stat_t;

endpackage

// ===== hw/rtl/epfl_req_if.sv =====
// Request channel: command beats into the entry pool.
interface epfl_req_if;
	logic                         valid;
	logic                         ready;
	logic [epfl_pkg::CMD_W-1:0]   cmd;
	logic [epfl_pkg::NUM_W-1:0]   entry_num;
	logic [epfl_pkg::DATA_W-1:0]  store_value;

	modport source(output valid, cmd, entry_num, store_value, input ready);
	modport sink(input valid, cmd, entry_num, store_value, output ready);
endinterface

// ===== hw/rtl/epfl_rsp_if.sv =====
// Response channel: result beats out of the entry pool.
interface epfl_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [epfl_pkg::STATUS_W-1:0] status;
	logic [epfl_pkg::NUM_W-1:0]    result_num;
	logic [epfl_pkg::DATA_W-1:0]   result_value;
	logic                          last;

	modport source(output valid, status, result_num, result_value, last, input ready);
	modport sink(input valid, status, result_num, result_value, last, output ready);
endinterface

// ===== hw/rtl/epfl_datapath.sv =====
// Datapath: list heads, link and value memories, walk pointers, result register.
`include "entry_pool_free_list_unit_assert.svh"
module epfl_datapath #(
	parameter int POOL_SIZE  = 32,
	parameter int VALUE_BITS = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [epfl_pkg::CMD_W-1:0]    req_cmd,
	input  logic [epfl_pkg::NUM_W-1:0]    req_entry_num,
	input  logic [epfl_pkg::DATA_W-1:0]   req_store_value,
	input  epfl_pkg::ctl_t                ctl,
	output epfl_pkg::stat_t               st,
	output logic                          rsp_valid,
	input  logic                          rsp_ready,
	output logic [epfl_pkg::STATUS_W-1:0] rsp_status,
	output logic [epfl_pkg::NUM_W-1:0]    rsp_result_num,
	output logic [epfl_pkg::DATA_W-1:0]   rsp_result_value,
	output logic                          rsp_last
);
	localparam int IDX_W  = $clog2(POOL_SIZE);
	localparam int LINK_W = IDX_W + 1;

	typedef logic [IDX_W-1:0]            idx_t;
	typedef logic [LINK_W-1:0]           link_t;
	typedef logic [VALUE_BITS-1:0]       value_t;
	typedef logic [epfl_pkg::NUM_W-1:0]  num_t;
	typedef logic [epfl_pkg::DATA_W-1:0] data_t;

	localparam idx_t          LAST_IDX = idx_t'(POOL_SIZE - 1);
	localparam logic [IDX_W:0] ONE_EXT = (IDX_W + 1)'(1);
	localparam logic [epfl_pkg::NUM_W:0] POOL_EXT = (epfl_pkg::NUM_W + 1)'(POOL_SIZE);

	function automatic num_t to_num(idx_t i);
		return num_t'({1'b0, i} + ONE_EXT);
	endfunction

	logic [epfl_pkg::CMD_W-1:0] cmd_q;
	num_t   num_q;
	value_t val_q;
	idx_t   free_head_q;
	logic   free_ok_q;
	idx_t   active_head_q;
	logic   active_ok_q;
	idx_t   cur_q;
	logic   cur_ok_q;
	idx_t   prev_q;
	logic   have_prev_q;

	link_t  link_mem [POOL_SIZE];
	value_t val_mem  [POOL_SIZE];
	logic [POOL_SIZE-1:0] link_vld_q;
	link_t  rd_link_s1;
	logic   rd_vld_s1;
	idx_t   rd_addr_s1;
	value_t rd_val_s1;

	logic   rd_en;
	idx_t   rd_addr;
	idx_t   rd_next;
	logic   rd_ok;
	logic   link_we;
	idx_t   link_wa;
	link_t  link_wd;
	idx_t   target;

	logic                          rsp_valid_q;
	logic [epfl_pkg::STATUS_W-1:0] rsp_status_q;
	num_t                          rsp_num_q;
	data_t                         rsp_value_q;
	logic                          rsp_last_q;

	assign rd_en   = ctl.rd_free || ctl.rd_cur;
	assign rd_addr = ctl.rd_free ? free_head_q : cur_q;

	// entries never written since reset hold the initial chain
	always_comb begin
		if (rd_vld_s1) begin
			rd_next = rd_link_s1[IDX_W-1:0];
			rd_ok   = rd_link_s1[IDX_W];
		end else begin
			rd_next = (rd_addr_s1 == LAST_IDX) ? '0 : rd_addr_s1 + 1'b1;
			rd_ok   = (rd_addr_s1 != LAST_IDX);
		end
	end

	always_comb begin
		link_we = 1'b0;
		link_wa = free_head_q;
		link_wd = {active_ok_q, active_head_q};
		if (ctl.alloc_commit) begin
			link_we = 1'b1;
		end else if (ctl.unlink && have_prev_q) begin
			link_we = 1'b1;
			link_wa = prev_q;
			link_wd = {rd_ok, rd_next};
		end else if (ctl.free_push) begin
			link_we = 1'b1;
			link_wa = cur_q;
			link_wd = {free_ok_q, free_head_q};
		end
	end

	always_ff @(posedge clk) begin
		if (link_we) begin
			link_mem[link_wa] <= link_wd;
		end
		if (ctl.alloc_commit) begin
			val_mem[free_head_q] <= val_q;
		end
		if (rd_en) begin
			rd_link_s1 <= link_mem[rd_addr];
			rd_val_s1  <= val_mem[rd_addr];
			rd_vld_s1  <= link_vld_q[rd_addr];
			rd_addr_s1 <= rd_addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_vld_q <= '0;
		end else if (link_we) begin
			link_vld_q[link_wa] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_head_q   <= '0;
			free_ok_q     <= 1'b1;
			active_head_q <= '0;
			active_ok_q   <= 1'b0;
			cur_ok_q      <= 1'b0;
			have_prev_q   <= 1'b0;
		end else begin
			if (ctl.load) begin
				cur_ok_q    <= active_ok_q;
				have_prev_q <= 1'b0;
			end
			if (ctl.walk_step) begin
				have_prev_q <= 1'b1;
			end
			if (ctl.walk_adv) begin
				cur_ok_q <= rd_ok;
			end
			if (ctl.alloc_commit) begin
				free_head_q   <= rd_next;
				free_ok_q     <= rd_ok;
				active_head_q <= free_head_q;
				active_ok_q   <= 1'b1;
			end
			if (ctl.unlink && !have_prev_q) begin
				active_head_q <= rd_next;
				active_ok_q   <= rd_ok;
			end
			if (ctl.free_push) begin
				free_head_q <= cur_q;
				free_ok_q   <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q <= req_cmd;
			num_q <= req_entry_num;
			val_q <= value_t'(req_store_value);
			cur_q <= active_head_q;
		end
		if (ctl.walk_step) begin
			prev_q <= cur_q;
		end
		if (ctl.walk_adv) begin
			cur_q <= rd_next;
		end
	end

	assign target = idx_t'(num_q - num_t'(1));

	assign st.cmd      = cmd_q;
	assign st.range_ok = (num_q != '0) && ({1'b0, num_q} <= POOL_EXT);
	assign st.free_ok  = free_ok_q;
	assign st.cur_ok   = cur_ok_q;
	assign st.cur_hit  = (cur_q == target);
	assign st.out_free = !rsp_valid_q || rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (ctl.emit) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.emit) begin
			rsp_status_q <= ctl.status;
			case (ctl.emit_sel)
				epfl_pkg::EMIT_ALLOC: begin
					rsp_num_q   <= to_num(free_head_q);
					rsp_value_q <= '0;
					rsp_last_q  <= 1'b1;
				end
				epfl_pkg::EMIT_LIST: begin
					rsp_num_q   <= to_num(cur_q);
					rsp_value_q <= data_t'(rd_val_s1);
					rsp_last_q  <= !rd_ok;
				end
				default: begin
					rsp_num_q   <= '0;
					rsp_value_q <= '0;
					rsp_last_q  <= 1'b1;
				end
			endcase
		end
	end

	assign rsp_valid        = rsp_valid_q;
	assign rsp_status       = rsp_status_q;
	assign rsp_result_num   = rsp_num_q;
	assign rsp_result_value = rsp_value_q;
	assign rsp_last         = rsp_last_q;

	`EPFL_ASSERT_IMPL(a_alloc_has_free, ctl.alloc_commit, free_ok_q)
	`EPFL_ASSERT_ALWAYS(a_one_link_write, $onehot0({ctl.alloc_commit, ctl.unlink, ctl.free_push}))
	`EPFL_ASSERT_IMPL(a_unlink_reads_cur, ctl.unlink || ctl.free_push, rd_addr_s1 == cur_q)

endmodule

// ===== hw/rtl/epfl_ctrl.sv =====
// Controller: sequences allocate, release walk and list walk over the datapath.
`include "entry_pool_free_list_unit_assert.svh"
module epfl_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_ready,
	input  epfl_pkg::stat_t st,
	output epfl_pkg::ctl_t  ctl
);
	localparam logic [3:0] S_IDLE       = 4'd0;
	localparam logic [3:0] S_DECODE     = 4'd1;
	localparam logic [3:0] S_ALLOC_WR   = 4'd2;
	localparam logic [3:0] S_REL_WALK   = 4'd3;
	localparam logic [3:0] S_REL_NEXT   = 4'd4;
	localparam logic [3:0] S_REL_UNLINK = 4'd5;
	localparam logic [3:0] S_REL_FREE   = 4'd6;
	localparam logic [3:0] S_LIST_RD    = 4'd7;
	localparam logic [3:0] S_LIST_EMIT  = 4'd8;
	localparam logic [3:0] S_RESP       = 4'd9;

	logic [3:0]                    state_q;
	logic [3:0]                    state_nxt;
	logic [epfl_pkg::STATUS_W-1:0] resp_status_q;
	logic [epfl_pkg::STATUS_W-1:0] resp_status_nxt;

	assign req_ready = (state_q == S_IDLE);

	always_comb begin
		ctl             = '0;
		ctl.emit_sel    = epfl_pkg::EMIT_STATUS;
		ctl.status      = epfl_pkg::ST_OK;
		state_nxt       = state_q;
		resp_status_nxt = resp_status_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					ctl.load  = 1'b1;
					state_nxt = S_DECODE;
				end
			end
			S_DECODE: begin
				unique case (st.cmd)
					epfl_pkg::CMD_ALLOC: begin
						if (st.free_ok) begin
							ctl.rd_free = 1'b1;
							state_nxt   = S_ALLOC_WR;
						end else begin
							resp_status_nxt = epfl_pkg::ST_EXHAUSTED;
							state_nxt       = S_RESP;
						end
					end
					epfl_pkg::CMD_RELEASE: begin
						if (st.range_ok) begin
							state_nxt = S_REL_WALK;
						end else begin
							resp_status_nxt = epfl_pkg::ST_RANGE;
							state_nxt       = S_RESP;
						end
					end
					epfl_pkg::CMD_LIST: begin
						state_nxt = S_LIST_RD;
					end
					default: begin
						state_nxt = S_IDLE;
					end
				endcase
			end
			S_ALLOC_WR: begin
				if (st.out_free) begin
					ctl.alloc_commit = 1'b1;
					ctl.emit         = 1'b1;
					ctl.emit_sel     = epfl_pkg::EMIT_ALLOC;
					state_nxt        = S_IDLE;
				end
			end
			S_REL_WALK: begin
				if (!st.cur_ok) begin
					resp_status_nxt = epfl_pkg::ST_NOT_ACTIVE;
					state_nxt       = S_RESP;
				end else if (st.cur_hit) begin
					ctl.rd_cur = 1'b1;
					state_nxt  = S_REL_UNLINK;
				end else begin
					ctl.rd_cur    = 1'b1;
					ctl.walk_step = 1'b1;
					state_nxt     = S_REL_NEXT;
				end
			end
			S_REL_NEXT: begin
				ctl.walk_adv = 1'b1;
				state_nxt    = S_REL_WALK;
			end
			S_REL_UNLINK: begin
				ctl.unlink = 1'b1;
				state_nxt  = S_REL_FREE;
			end
			S_REL_FREE: begin
				ctl.free_push   = 1'b1;
				resp_status_nxt = epfl_pkg::ST_OK;
				state_nxt       = S_RESP;
			end
			S_LIST_RD: begin
				if (st.cur_ok) begin
					ctl.rd_cur = 1'b1;
					state_nxt  = S_LIST_EMIT;
				end else begin
					state_nxt = S_IDLE;
				end
			end
			S_LIST_EMIT: begin
				if (st.out_free) begin
					ctl.emit     = 1'b1;
					ctl.emit_sel = epfl_pkg::EMIT_LIST;
					ctl.walk_adv = 1'b1;
					state_nxt    = S_LIST_RD;
				end
			end
			S_RESP: begin
				if (st.out_free) begin
					ctl.emit   = 1'b1;
					ctl.status = resp_status_q;
					state_nxt  = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			resp_status_q <= epfl_pkg::ST_OK;
		end else begin
			state_q       <= state_nxt;
			resp_status_q <= resp_status_nxt;
		end
	end

	`EPFL_ASSERT_IMPL(a_emit_slot_free, ctl.emit, st.out_free)
	`EPFL_ASSERT_IMPL(a_decode_after_accept, state_q == S_DECODE, $past(req_valid && req_ready))

endmodule

// ===== hw/rtl/entry_pool_free_list_unit.sv =====
// Top level of the entry pool free list unit: controller plus datapath.
// Usage:
//   req carries one command beat (cmd, entry_num, store_value); rsp carries result
//   beats (status, result_num, result_value, last), valid/ready on both.
//   Allocate and release give exactly one beat with last set; list gives one beat
//   per active entry, newest first, last on the oldest; an empty list or an
//   unused cmd gives no beat.
//   One command is worked at a time; req.ready is high while the unit is idle.
//   Each list step has a read state and an emit state, since the link memory
//   read is registered.
//   A result beat sits in an output register, so the next command is accepted
//   while it waits; when rsp is stalled, a list walk holds until the register frees.
//   Reset empties the active list and chains all entries into the free list,
//   entry 1 first; it takes effect at once, with no sweep.
module entry_pool_free_list_unit #(
	parameter int POOL_SIZE  = 32,
	parameter int VALUE_BITS = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	epfl_req_if.sink   req,
	epfl_rsp_if.source rsp
);
	epfl_pkg::ctl_t  ctl;
	epfl_pkg::stat_t st;

	epfl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.st        (st),
		.ctl       (ctl)
	);

	epfl_datapath #(
		.POOL_SIZE  (POOL_SIZE),
		.VALUE_BITS (VALUE_BITS)
	) u_datapath (
		.clk              (clk),
		.arst_n           (arst_n),
		.req_cmd          (req.cmd),
		.req_entry_num    (req.entry_num),
		.req_store_value  (req.store_value),
		.ctl              (ctl),
		.st               (st),
		.rsp_valid        (rsp.valid),
		.rsp_ready        (rsp.ready),
		.rsp_status       (rsp.status),
		.rsp_result_num   (rsp.result_num),
		.rsp_result_value (rsp.result_value),
		.rsp_last         (rsp.last)
	);

endmodule
